// File: rtl/core/rtba_pkg.sv
// Shared types, constants and arithmetic helpers for the Tait-Bryan angle unit.
package rtba_pkg;

  localparam int unsigned FRAC_BITS     = 30;
  localparam int unsigned CORDIC_STAGES = 30;

  // Square root digit recurrence: one result bit per stage.
  localparam int unsigned SQ_N   = FRAC_BITS + 1;
  localparam int unsigned SQ_S_W = 2 * SQ_N;
  localparam int unsigned SQ_R_W = SQ_N + 3;

  // CORDIC datapath widths (x/y grow by about 1.65 * sqrt(2)).
  localparam int unsigned OP_W = 33;
  localparam int unsigned CW   = 36;
  localparam int unsigned ZW   = 34;

  localparam logic signed [31:0]     ONE_Q   = 32'(64'd1 << FRAC_BITS);
  localparam logic [SQ_S_W-1:0]      S_ONE   = SQ_S_W'(128'd1 << (2 * FRAC_BITS));
  localparam logic signed [ZW-1:0]   ANG_PI  = ZW'(64'sd1686629713);
  localparam logic signed [ZW-1:0]   ANG_HPI = ZW'(64'sd843314857);

  typedef enum logic [1:0] {
    BR_GEN   = 2'd0,
    BR_MINUS = 2'd1,
    BR_PLUS  = 2'd2
  } branch_e;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    branch_e     br;
  } side_t;

  typedef struct packed {
    logic signed [OP_W-1:0] ry;
    logic signed [OP_W-1:0] rx;
    logic signed [OP_W-1:0] yy;
    logic signed [OP_W-1:0] yx;
    logic signed [OP_W-1:0] py;
  } opnd_t;

  typedef struct packed {
    logic [SQ_S_W-1:0] s;
    logic [SQ_R_W-1:0] rem;
    logic [SQ_N-1:0]   res;
  } sqst_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  function automatic logic signed [ZW-1:0] atan_step(input int i);
    logic signed [ZW-1:0] r;
    unique case (i)
      0: r = ZW'(64'sd421657428);
      1: r = ZW'(64'sd248918915);
      2: r = ZW'(64'sd131521918);
      3: r = ZW'(64'sd66762579);
      4: r = ZW'(64'sd33510843);
      5: r = ZW'(64'sd16771758);
      6: r = ZW'(64'sd8387925);
      7: r = ZW'(64'sd4194219);
      8: r = ZW'(64'sd2097141);
      9: r = ZW'(64'sd1048575);
      default: begin
        if (i < 30) r = ZW'(64'sd1 <<< (29 - i));
        else        r = '0;
      end
    endcase
    return r;
  endfunction

  // One restoring square root step on bit pair k of the radicand.
  function automatic sqst_t sqrt_step(input sqst_t a, input int k);
    sqst_t               o;
    logic [SQ_R_W-1:0]   rn;
    logic [SQ_R_W-1:0]   t;
    rn = {a.rem[SQ_R_W-3:0], a.s[2*k +: 2]};
    t  = {1'b0, a.res, 2'b01};
    o.s = a.s;
    if (rn >= t) begin
      o.rem = rn - t;
      o.res = {a.res[SQ_N-2:0], 1'b1};
    end else begin
      o.rem = rn;
      o.res = {a.res[SQ_N-2:0], 1'b0};
    end
    return o;
  endfunction

  // Quadrant fold so that x >= 0 before the vectoring stages.
  function automatic lane_t prerot(input logic signed [OP_W-1:0] y_in,
                                   input logic signed [OP_W-1:0] x_in);
    lane_t                o;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    x = CW'(x_in);
    y = CW'(y_in);
    o.zero = (x_in == '0) && (y_in == '0);
    if (x < 0) begin
      if (y >= 0) begin
        o.x = y;
        o.y = -x;
        o.z = ANG_HPI;
      end else begin
        o.x = -y;
        o.y = x;
        o.z = -ANG_HPI;
      end
    end else begin
      o.x = x;
      o.y = y;
      o.z = '0;
    end
    return o;
  endfunction

  function automatic lane_t cstep(input lane_t a, input int i);
    lane_t                o;
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    x  = a.x;
    y  = a.y;
    xs = x >>> i;
    ys = y >>> i;
    o.zero = a.zero;
    if (y >= 0) begin
      o.x = x + ys;
      o.y = y - xs;
      o.z = a.z + atan_step(i);
    end else begin
      o.x = x - ys;
      o.y = y + xs;
      o.z = a.z - atan_step(i);
    end
    return o;
  endfunction

  function automatic logic signed [ZW-1:0] clamp(input logic signed [ZW-1:0] v,
                                                 input logic signed [ZW-1:0] lim);
    logic signed [ZW-1:0] r;
    if (v > lim)       r = lim;
    else if (v < -lim) r = -lim;
    else               r = v;
    return r;
  endfunction

endpackage

// File: rtl/core/rotation_to_tait_bryan_angles_unit.sv
// Top level: pipelined rotation matrix to roll/pitch/yaw extraction.
//
//  channel  | dir | tdata (low bit up)                              | tuser
//  s_axis   | in  | rot_00 rot_01 rot_02 rot_10 rot_11 rot_12 rot_22  | -
//           |     | trans_x trans_y trans_z                         |
//  m_axis   | out | pos_x pos_y pos_z roll pitch yaw, 1 pad bit      | branch
//
// One request per cycle while m_axis is not stalled. Stages: input and squaring stages,
// 31 square root stages (one result bit each), a quadrant fold stage,
// 30 CORDIC stages, and the output register.
// Reset clears only the stage valid bits. A stall at m_axis freezes the whole pipe;
// s_axis_tready is high when the output register is empty or m_axis_tready is high.
module rotation_to_tait_bryan_angles_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_22, trans_x, trans_y, trans_z
  input  logic [319:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, pos_z, roll, pitch(31), yaw, zero pad
  output logic [191:0] m_axis_tdata,
  // branch
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned NSQ = rtba_pkg::SQ_N;
  localparam int unsigned NC  = rtba_pkg::CORDIC_STAGES;

  logic en;

  // input stage
  logic          v0_q;
  logic [319:0]  d0_q;

  // square stage
  logic                     v1_q;
  rtba_pkg::side_t          side1_q, side1_d;
  rtba_pkg::opnd_t          op1_q, op1_d;
  logic [rtba_pkg::SQ_S_W-1:0] sq1_q, sq1_d;

  // square root stages
  logic            sv_q    [NSQ];
  rtba_pkg::side_t sside_q [NSQ];
  rtba_pkg::opnd_t sop_q   [NSQ];
  rtba_pkg::sqst_t sst_q   [NSQ];
  rtba_pkg::sqst_t sst_in  [NSQ];

  // fold + CORDIC stages: index 0 is the fold stage
  logic            cv_q    [NC+1];
  rtba_pkg::side_t cside_q [NC+1];
  rtba_pkg::lane_t lr_q    [NC+1];
  rtba_pkg::lane_t ly_q    [NC+1];
  rtba_pkg::lane_t lp_q    [NC+1];

  // output
  logic            out_v_q;
  logic [191:0]    out_d_q, out_d_d;
  logic [1:0]      out_u_q;

  assign en            = ~out_v_q | m_axis_tready;
  assign s_axis_tready = en;

  // square stage logic
  always_comb begin
    logic signed [31:0] r00, r01, r02, r10, r11, r12, r22;
    logic signed [63:0] prod;
    r00 = d0_q[31:0];
    r01 = d0_q[63:32];
    r02 = d0_q[95:64];
    r10 = d0_q[127:96];
    r11 = d0_q[159:128];
    r12 = d0_q[191:160];
    r22 = d0_q[223:192];
    prod = r02 * r02;
    sq1_d = prod[rtba_pkg::SQ_S_W-1:0];
    side1_d.px = d0_q[255:224];
    side1_d.py = d0_q[287:256];
    side1_d.pz = d0_q[319:288];
    priority if (r02 >= rtba_pkg::ONE_Q)  side1_d.br = rtba_pkg::BR_PLUS;
    else if (r02 <= -rtba_pkg::ONE_Q)     side1_d.br = rtba_pkg::BR_MINUS;
    else                                  side1_d.br = rtba_pkg::BR_GEN;
    if (side1_d.br != rtba_pkg::BR_GEN) begin
      op1_d.ry = 33'(r10);
      op1_d.rx = 33'(r11);
    end else begin
      op1_d.ry = -33'(r12);
      op1_d.rx = 33'(r22);
    end
    op1_d.yy = -33'(r01);
    op1_d.yx = 33'(r00);
    op1_d.py = 33'(r02);
  end

  always_comb begin
    sst_in[0].s   = rtba_pkg::S_ONE - sq1_q;
    sst_in[0].rem = '0;
    sst_in[0].res = '0;
    for (int j = 1; j < NSQ; j++) begin
      sst_in[j] = sst_q[j-1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
      out_v_q <= 1'b0;
      for (int j = 0; j < NSQ; j++) sv_q[j] <= 1'b0;
      for (int j = 0; j <= NC; j++) cv_q[j] <= 1'b0;
    end else if (en) begin
      v0_q    <= s_axis_tvalid;
      v1_q    <= v0_q;
      sv_q[0] <= v1_q;
      for (int j = 1; j < NSQ; j++) sv_q[j] <= sv_q[j-1];
      cv_q[0] <= sv_q[NSQ-1];
      for (int j = 1; j <= NC; j++) cv_q[j] <= cv_q[j-1];
      out_v_q <= cv_q[NC];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      d0_q    <= s_axis_tdata;
      side1_q <= side1_d;
      op1_q   <= op1_d;
      sq1_q   <= sq1_d;
      sside_q[0] <= side1_q;
      sop_q[0]   <= op1_q;
      for (int j = 1; j < NSQ; j++) begin
        sside_q[j] <= sside_q[j-1];
        sop_q[j]   <= sop_q[j-1];
      end
      for (int j = 0; j < NSQ; j++) begin
        sst_q[j] <= rtba_pkg::sqrt_step(sst_in[j], NSQ - 1 - j);
      end
      cside_q[0] <= sside_q[NSQ-1];
      lr_q[0] <= rtba_pkg::prerot(sop_q[NSQ-1].ry, sop_q[NSQ-1].rx);
      ly_q[0] <= rtba_pkg::prerot(sop_q[NSQ-1].yy, sop_q[NSQ-1].yx);
      lp_q[0] <= rtba_pkg::prerot(sop_q[NSQ-1].py,
                                  rtba_pkg::OP_W'(sst_q[NSQ-1].res));
      for (int i = 0; i < NC; i++) begin
        cside_q[i+1] <= cside_q[i];
        lr_q[i+1]    <= rtba_pkg::cstep(lr_q[i], i);
        ly_q[i+1]    <= rtba_pkg::cstep(ly_q[i], i);
        lp_q[i+1]    <= rtba_pkg::cstep(lp_q[i], i);
      end
      out_d_q <= out_d_d;
      out_u_q <= cside_q[NC].br;
    end
  end

  // final clamp and branch selection
  always_comb begin
    logic signed [rtba_pkg::ZW-1:0] a_r, a_y, a_p, roll, pitch, yaw;
    a_r = lr_q[NC].zero ? '0 : rtba_pkg::clamp(lr_q[NC].z, rtba_pkg::ANG_PI);
    a_y = ly_q[NC].zero ? '0 : rtba_pkg::clamp(ly_q[NC].z, rtba_pkg::ANG_PI);
    a_p = lp_q[NC].zero ? '0 : rtba_pkg::clamp(lp_q[NC].z, rtba_pkg::ANG_PI);
    unique case (cside_q[NC].br)
      rtba_pkg::BR_PLUS: begin
        roll  = a_r;
        pitch = rtba_pkg::ANG_HPI;
        yaw   = '0;
      end
      rtba_pkg::BR_MINUS: begin
        roll  = -a_r;
        pitch = -rtba_pkg::ANG_HPI;
        yaw   = '0;
      end
      default: begin
        roll  = a_r;
        pitch = rtba_pkg::clamp(a_p, rtba_pkg::ANG_HPI);
        yaw   = a_y;
      end
    endcase
    out_d_d = {1'b0, yaw[31:0], pitch[30:0], roll[31:0],
               cside_q[NC].pz, cside_q[NC].py, cside_q[NC].px};
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_d_q;
  assign m_axis_tuser  = out_u_q;

endmodule

// File: rtl/core/rtba_checker.sv
// Port-level assertions for the Tait-Bryan angle unit, bound to the top level.
module rtba_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [191:0] m_axis_tdata,
  input logic [1:0]   m_axis_tuser
);

  a_branch_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == rtba_pkg::BR_GEN ||
                       m_axis_tuser == rtba_pkg::BR_MINUS ||
                       m_axis_tuser == rtba_pkg::BR_PLUS))
    else $error("bad branch code");

  a_lock_yaw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != rtba_pkg::BR_GEN) |-> m_axis_tdata[190:159] == '0)
    else $error("yaw not zero in lock");

  a_plus_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == rtba_pkg::BR_PLUS)
      |-> m_axis_tdata[158:128] == rtba_pkg::ANG_HPI[30:0])
    else $error("pitch not +pi/2 in lock");

  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("accepting while output stalled");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output dropped under stall");

endmodule

bind rotation_to_tait_bryan_angles_unit rtba_checker u_rtba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: dv/tb_top.sv
// Testbench for the pose-to-Tait-Bryan angle unit: directed and random poses, checked result by result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY = 65;
  localparam longint      ONE     = 64'sd1 << rtba_pkg::FRAC_BITS;
  localparam longint      A_PI    = 64'sd1686629713;
  localparam longint      A_HPI   = 64'sd843314857;

  typedef struct {
    logic [31:0] px, py, pz, roll;
    logic [30:0] pitch;
    logic [31:0] yaw;
    rtba_pkg::branch_e br;
  } pose_angles_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [319:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [191:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  pose_angles_t angles_q[$];
  int           n_errors = 0;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  int           hold_off = 0;

  rotation_to_tait_bryan_angles_unit dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint sat(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint atan_const(int i);
    case (i)
      0: return 421657428;
      1: return 248918915;
      2: return 131521918;
      3: return 66762579;
      4: return 33510843;
      5: return 16771758;
      6: return 8387925;
      7: return 4194219;
      8: return 2097141;
      9: return 1048575;
      default: return (i < 30) ? (64'sd1 << (29 - i)) : 0;
    endcase
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = A_HPI;
      end else begin
        x = -y; y = t; z = -A_HPI;
      end
    end
    for (int i = 0; i < rtba_pkg::CORDIC_STAGES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z += atan_const(i);
      end else begin
        x = x - ys; y = y + xs; z -= atan_const(i);
      end
    end
    return sat(z, A_PI);
  endfunction

  function automatic longint floor_sqrt(logic [63:0] s);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic pose_angles_t predict_angles(logic [319:0] d);
    pose_angles_t a;
    longint r00, r01, r02, r10, r11, r12, r22, c, roll, pitch, yaw;
    r00 = longint'($signed(d[31:0]));
    r01 = longint'($signed(d[63:32]));
    r02 = longint'($signed(d[95:64]));
    r10 = longint'($signed(d[127:96]));
    r11 = longint'($signed(d[159:128]));
    r12 = longint'($signed(d[191:160]));
    r22 = longint'($signed(d[223:192]));
    if (r02 >= ONE) begin
      a.br = rtba_pkg::BR_PLUS; pitch = A_HPI; roll = vector_angle(r10, r11); yaw = 0;
    end else if (r02 <= -ONE) begin
      a.br = rtba_pkg::BR_MINUS; pitch = -A_HPI; roll = -vector_angle(r10, r11); yaw = 0;
    end else begin
      c = floor_sqrt(64'(ONE * ONE) - 64'(r02 * r02));
      a.br = rtba_pkg::BR_GEN;
      pitch = sat(vector_angle(r02, c), A_HPI);
      roll = vector_angle(-r12, r22);
      yaw = vector_angle(-r01, r00);
    end
    a.px = d[255:224];
    a.py = d[287:256];
    a.pz = d[319:288];
    a.roll = roll[31:0];
    a.pitch = pitch[30:0];
    a.yaw = yaw[31:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: %s mismatch: got %h want %h", $realtime, what, got, want);
    n_errors++;
  endtask

  // tvalid stays up after an accept; it drops only on an idle cycle or a drain
  task automatic send_pose(logic [31:0] r[7], logic [31:0] t[3]);
    logic [319:0] d;
    d = {t[2], t[1], t[0], r[6], r[5], r[4], r[3], r[2], r[1], r[0]};
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    angles_q.insert(angles_q.size(), predict_angles(d));
  endtask

  // receiver: random backpressure plus optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pose_angles_t w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (angles_q.size() == 0) begin
        report_mismatch("unexpected request", 32'(m_axis_tuser), '0);
      end else begin
        w = angles_q.pop_front();
        if (m_axis_tdata[31:0] !== w.px) report_mismatch("pos_x", m_axis_tdata[31:0], w.px);
        if (m_axis_tdata[63:32] !== w.py) report_mismatch("pos_y", m_axis_tdata[63:32], w.py);
        if (m_axis_tdata[95:64] !== w.pz) report_mismatch("pos_z", m_axis_tdata[95:64], w.pz);
        if (m_axis_tdata[127:96] !== w.roll)
          report_mismatch("roll", m_axis_tdata[127:96], w.roll);
        if (m_axis_tdata[158:128] !== w.pitch)
          report_mismatch("pitch", 32'(m_axis_tdata[158:128]), 32'(w.pitch));
        if (m_axis_tdata[190:159] !== w.yaw)
          report_mismatch("yaw", m_axis_tdata[190:159], w.yaw);
        if (m_axis_tuser !== w.br) report_mismatch("branch", 32'(m_axis_tuser), 32'(w.br));
      end
    end
  end

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(9))
      0: return 32'(ONE);
      1: return 32'(-ONE);
      2: return 32'($urandom_range(1, 16));
      3: return $urandom;
      4: return 32'(ONE) - $urandom_range(0, 255);
      5: return 32'(-ONE) + $urandom_range(0, 255);
      default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
    endcase
  endfunction

  task automatic send_random_pose();
    logic [31:0] r[7];
    logic [31:0] t[3];
    foreach (r[i]) r[i] = rand_entry();
    foreach (t[i]) t[i] = $urandom;
    send_pose(r, t);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (angles_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [31:0] z7[7] = '{default: 0};
    logic [31:0] t0[3] = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000};
    logic [31:0] t1[3] = '{32'h7FFF_FFFF, 32'h5555_AAAA, 32'hAAAA_5555};
    logic [31:0] r[7];
    logic [31:0] e;
    send_pose(z7, t0);  // all-zero operands
    r = '{32'(ONE), 0, 0, 0, 32'(ONE), 0, 32'(ONE)};
    send_pose(r, t1);  // identity
    for (int k = 0; k < 4; k++) begin
      e = (k[0]) ? 32'(-ONE) : 32'(ONE);
      r = '{0, 0, (k < 2) ? 32'(ONE) : 32'(-ONE), e, (k[0]) ? 32'(ONE) : 0, 0, 0};
      send_pose(r, t0);  // both lock cases
    end
    r = '{0, 0, 32'(ONE) + 5, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0};
    send_pose(r, t1);  // past plus lock
    r = '{0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0};
    send_pose(r, t1);  // past minus lock
    r = '{32'h8000_0000, 32'h7FFF_FFFF, 32'(ONE) - 1, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
    send_pose(r, t0);  // just inside plus lock, extreme operands
    r = '{32'(-ONE), 32'(-ONE), 32'(-ONE) + 1, 0, 0, 32'(ONE), 32'(-ONE)};
    send_pose(r, t1);  // just inside minus lock, negative x
    r = '{32'(-ONE), 0, 0, 0, 0, 0, 32'(-ONE)};
    send_pose(r, t1);  // y zero with x negative
    r = '{0, 32'(-ONE), 0, 0, 0, 32'(ONE), 0};
    send_pose(r, t0);  // x zero
    for (int k = 0; k < 10; k++) send_random_pose();
    wait_drained();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) send_random_pose();
  endtask

  task automatic test_backpressure();
    hold_off = 300;  // receiver stalls long; sender keeps offering
    for (int k = 0; k < 120; k++) send_random_pose();
    wait_drained();
    for (int k = 0; k < 20; k++) send_random_pose();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_idle_pct = 12; recv_idle_pct = 76;
    test_random(200);
    send_idle_pct = 76; recv_idle_pct = 12;
    test_random(200);
    send_idle_pct = 0; recv_idle_pct = 0;
    test_random(160);
    test_backpressure();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (n_errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end
endmodule
